[hdl/bces_pkg.sv]
// types and constants shared by the byte compare syndrome checker
// no dependencies; imported by every module of the block
`default_nettype none

package bces_pkg;

  localparam int MAX_BYTES = 65536;
  localparam int LANES     = 8;
  localparam int LANE_W    = 3;
  localparam int CNT17_MAX = 32'h1FFFF;
  localparam int CNT20_MAX = 32'hFFFFF;
  localparam int POS_MAX   = 32'hFFFF;

  // position counter stops here; recorded position clamps to POS_LIMIT
  localparam int POS_CAP   = (MAX_BYTES > CNT17_MAX) ? CNT17_MAX : MAX_BYTES;
  localparam int POS_LIMIT = ((MAX_BYTES - 1) > POS_MAX) ? POS_MAX : (MAX_BYTES - 1);

  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  typedef logic [16:0] count17_t;

  typedef struct packed {
    logic [7:0] expected_byte;
    logic [7:0] observed_byte;
    logic       final_pair;
  } pair_t;

  typedef struct packed {
    logic [2:0]  lane_number;
    logic [16:0] lane_error_count;
    logic [16:0] bad_byte_total;
    logic [19:0] bad_bit_total;
    logic [15:0] span_start;
    logic [16:0] span_width;
    logic [7:0]  fault_mask;
    logic        mismatch_seen;
    logic        final_result;
  } result_t;

  // one finished run, as handed from the front to the back
  typedef struct packed {
    count17_t [LANES-1:0] lane_counts;
    logic [16:0]          bad_bytes;
    logic [19:0]          bad_bits;
    logic [15:0]          span_start;
    logic [16:0]          span_width;
    logic [7:0]           fault_mask;
    logic                 any_bad;
  } summary_t;

  typedef struct packed {
    logic     valid;
    summary_t data;
  } q_write_t;

  typedef struct packed {
    logic     valid;
    summary_t data;
  } q_head_t;

endpackage

`default_nettype wire

[hdl/byte_compare_error_syndrome_top.sv]
// top level of the byte compare error syndrome checker
// uses bces_pkg, bces_front, bces_queue and bces_back
`default_nettype none

// Takes one expected/observed byte pair per cycle while full is low and keeps
// the mismatch syndrome of the run: bad byte and bad bit counts, first and
// last bad position, the OR of difference masks and a count per bit lane. The
// pair marked final_pair closes the run; eight results follow, lane 0 to lane
// 7, one per cycle while pop is held, with final_result set on lane 7. Pairs
// are accepted in each cycle in which full is low, including the cycle of a
// final pair. Finished runs wait in a two-entry summary queue, and each drains
// as eight results, so full rises only when two runs are still waiting to be
// read out; a steady stream of runs shorter than eight pairs is paced by that
// readout.

module byte_compare_error_syndrome_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire bces_pkg::pair_t    pair,
  output logic                    empty,
  input  wire logic               pop,
  output bces_pkg::result_t       result
);
  import bces_pkg::*;

  q_write_t q_wr;
  q_head_t  q_head;
  logic     q_full;
  logic     release_head;
  logic     accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  bces_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .pair   (pair),
    .q_wr   (q_wr)
  );

  bces_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .q_wr         (q_wr),
    .release_head (release_head),
    .q_head       (q_head),
    .q_full       (q_full)
  );

  bces_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_head       (q_head),
    .pop          (pop),
    .empty        (empty),
    .result       (result),
    .release_head (release_head)
  );

endmodule

`default_nettype wire

[hdl/bces_front.sv]
// front end: compares each accepted byte pair and updates the run accumulators
// uses bces_pkg; writes a run summary into bces_queue on the final pair
`default_nettype none

module bces_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire bces_pkg::pair_t   pair,
  output bces_pkg::q_write_t     q_wr
);
  import bces_pkg::*;

  logic [16:0]          position;
  logic [16:0]          bad_bytes;
  logic [19:0]          bad_bits;
  logic [15:0]          first_bad;
  logic [15:0]          last_bad;
  logic                 any_bad;
  logic [7:0]           or_mask;
  count17_t [LANES-1:0] lane_counts;

  logic [16:0]          position_next;
  logic [16:0]          bad_bytes_next;
  logic [19:0]          bad_bits_next;
  logic [15:0]          first_bad_next;
  logic [15:0]          last_bad_next;
  logic                 any_bad_next;
  logic [7:0]           or_mask_next;
  count17_t [LANES-1:0] lane_counts_next;

  logic [7:0]  diff;
  logic [3:0]  ones;
  logic [15:0] pos;
  logic [20:0] bits_sum;

  always_comb begin
    diff = pair.expected_byte ^ pair.observed_byte;
    ones = '0;
    for (int b = 0; b < 8; b++) begin
      ones = ones + 4'(diff[b]);
    end

    pos = (32'(position) > POS_LIMIT) ? 16'(POS_LIMIT) : position[15:0];

    position_next    = (32'(position) < POS_CAP) ? position + 17'd1 : position;
    bad_bytes_next   = bad_bytes;
    bad_bits_next    = bad_bits;
    first_bad_next   = first_bad;
    last_bad_next    = last_bad;
    any_bad_next     = any_bad;
    or_mask_next     = or_mask;
    lane_counts_next = lane_counts;
    bits_sum         = 21'(bad_bits) + 21'(ones);

    if (diff != 8'd0) begin
      if (!any_bad) begin
        first_bad_next = pos;
      end
      last_bad_next  = pos;
      any_bad_next   = 1'b1;
      or_mask_next   = or_mask | diff;
      bad_bytes_next = (32'(bad_bytes) >= CNT17_MAX) ? 17'(CNT17_MAX) : bad_bytes + 17'd1;
      bad_bits_next  = (32'(bits_sum) > CNT20_MAX) ? 20'(CNT20_MAX) : bits_sum[19:0];
      for (int l = 0; l < LANES; l++) begin
        if (diff[l] && (32'(lane_counts[l]) < CNT17_MAX)) begin
          lane_counts_next[l] = lane_counts[l] + 17'd1;
        end
      end
    end
  end

  // summary of the run including this pair
  always_comb begin
    q_wr.valid            = accept && pair.final_pair;
    q_wr.data.lane_counts = lane_counts_next;
    q_wr.data.bad_bytes   = bad_bytes_next;
    q_wr.data.bad_bits    = bad_bits_next;
    q_wr.data.span_start  = any_bad_next ? first_bad_next : 16'd0;
    q_wr.data.span_width  = any_bad_next
                          ? ({1'b0, last_bad_next} - {1'b0, first_bad_next} + 17'd1)
                          : 17'd0;
    q_wr.data.fault_mask  = or_mask_next;
    q_wr.data.any_bad     = any_bad_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && pair.final_pair)) begin
      position    <= '0;
      bad_bytes   <= '0;
      bad_bits    <= '0;
      first_bad   <= '0;
      last_bad    <= '0;
      any_bad     <= 1'b0;
      or_mask     <= '0;
      lane_counts <= '0;
    end else if (accept) begin
      position    <= position_next;
      bad_bytes   <= bad_bytes_next;
      bad_bits    <= bad_bits_next;
      first_bad   <= first_bad_next;
      last_bad    <= last_bad_next;
      any_bad     <= any_bad_next;
      or_mask     <= or_mask_next;
      lane_counts <= lane_counts_next;
    end
  end

endmodule

`default_nettype wire

[hdl/bces_queue.sv]
// short queue of finished run summaries between front and back
// uses bces_pkg; head entry is read by bces_back
`default_nettype none

module bces_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bces_pkg::q_write_t  q_wr,
  input  wire logic                release_head,
  output bces_pkg::q_head_t        q_head,
  output logic                     q_full
);
  import bces_pkg::*;

  summary_t             entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 do_wr;
  logic                 do_rd;

  assign q_full      = (32'(count) == Q_DEPTH);
  assign q_head.valid = (count != '0);
  assign q_head.data  = entries[rd_ptr];
  assign do_wr       = q_wr.valid && !q_full;
  assign do_rd       = release_head && q_head.valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= q_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (32'(wr_ptr) == Q_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (32'(rd_ptr) == Q_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/bces_back.sv]
// back end: walks the head summary lane by lane and forms the result
// uses bces_pkg; releases the queue head after the lane 7 result is taken
`default_nettype none

module bces_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bces_pkg::q_head_t  q_head,
  input  wire logic               pop,
  output logic                    empty,
  output bces_pkg::result_t       result,
  output logic                    release_head
);
  import bces_pkg::*;

  logic [LANE_W-1:0] lane;
  logic              taken;
  logic              last_lane;

  assign empty     = !q_head.valid;
  assign taken     = pop && q_head.valid;
  assign last_lane = (32'(lane) == LANES - 1);
  assign release_head = taken && last_lane;

  always_comb begin
    result.lane_number      = lane;
    result.lane_error_count = q_head.data.lane_counts[lane];
    result.bad_byte_total   = q_head.data.bad_bytes;
    result.bad_bit_total    = q_head.data.bad_bits;
    result.span_start       = q_head.data.span_start;
    result.span_width       = q_head.data.span_width;
    result.fault_mask       = q_head.data.fault_mask;
    result.mismatch_seen    = q_head.data.any_bad;
    result.final_result     = last_lane;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane <= '0;
    end else if (taken) begin
      lane <= last_lane ? '0 : lane + 1'b1;
    end
  end

endmodule

`default_nettype wire

[hdl/bces_checker.sv]
// port level checks for the byte compare error syndrome checker
// uses bces_pkg; bound to byte_compare_error_syndrome_top
`default_nettype none

module bces_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               push,
  input wire logic               full,
  input wire bces_pkg::pair_t    pair,
  input wire logic               empty,
  input wire logic               pop,
  input wire bces_pkg::result_t  result
);
  import bces_pkg::*;

  // nothing to read right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // lanes of a run come out in order without gaps
  a_lane_order: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && (result.lane_number != 3'd7))
      |=> (!empty && (result.lane_number == $past(result.lane_number) + 3'd1)))
    else $error("lane results out of order");

  // final_result marks exactly the lane 7 request
  a_final_flag: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.final_result == (result.lane_number == 3'd7)))
    else $error("final_result not on lane 7");

  // a clean run reports no span and no mask
  a_clean_run: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.mismatch_seen)
      |-> ((result.span_width == 17'd0) && (result.fault_mask == 8'd0)
           && (result.bad_byte_total == 17'd0)))
    else $error("clean run reports a mismatch summary");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed");

endmodule

bind byte_compare_error_syndrome_top bces_checker u_bces_checker (.*);

`default_nettype wire

[tb/sv/tb.sv]
// testbench for byte_compare_error_syndrome_top: drives byte pairs, predicts per-lane syndromes
// depends on bces_pkg and the block's top level; the scoreboard class lives inside module tb

module tb;
  import bces_pkg::*;

  class syndrome_board;
    result_t     due_lanes[$];
    int          errors;
    logic [16:0] position;
    logic [16:0] bad_bytes;
    logic [19:0] bad_bits;
    logic [15:0] first_bad;
    logic [15:0] last_bad;
    logic        any_bad;
    logic [7:0]  or_mask;
    logic [16:0] lane_counts[LANES];

    function new();
      errors = 0;
      clear_run();
    endfunction

    function void clear_run();
      int k;
      position  = '0;
      bad_bytes = '0;
      bad_bits  = '0;
      first_bad = '0;
      last_bad  = '0;
      any_bad   = 1'b0;
      or_mask   = '0;
      for (k = 0; k < LANES; k++) lane_counts[k] = '0;
    endfunction

    function logic [16:0] bump17(logic [16:0] v);
      return (v == 17'(CNT17_MAX)) ? v : v + 17'd1;
    endfunction

    // fold one accepted request into the run; a final pair queues eight lane reports
    function void accumulate_pair(pair_t p);
      logic [7:0]  diff;
      logic [15:0] at;
      logic [19:0] ones;
      result_t     r;
      int          k;
      diff = p.expected_byte ^ p.observed_byte;
      at = (position > POS_LIMIT) ? 16'(POS_LIMIT) : position[15:0];
      if (diff != 8'd0) begin
        if (!any_bad) first_bad = at;
        last_bad  = at;
        any_bad   = 1'b1;
        or_mask   = or_mask | diff;
        bad_bytes = bump17(bad_bytes);
        ones      = 20'($countones(diff));
        bad_bits  = (bad_bits > 20'(CNT20_MAX) - ones) ? 20'(CNT20_MAX) : bad_bits + ones;
        for (k = 0; k < LANES; k++)
          if (diff[k]) lane_counts[k] = bump17(lane_counts[k]);
      end
      if (position < POS_CAP) position = position + 17'd1;
      if (p.final_pair) begin
        for (k = 0; k < LANES; k++) begin
          r.lane_number      = 3'(k);
          r.lane_error_count = lane_counts[k];
          r.bad_byte_total   = bad_bytes;
          r.bad_bit_total    = bad_bits;
          r.span_start       = any_bad ? first_bad : 16'd0;
          r.span_width       = any_bad ? 17'(last_bad) - 17'(first_bad) + 17'd1 : 17'd0;
          r.fault_mask       = or_mask;
          r.mismatch_seen    = any_bad;
          r.final_result     = (k == LANES - 1);
          due_lanes.push_back(r);
        end
        clear_run();
      end
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void compare(string name, int lane, logic [31:0] want, logic [31:0] got);
      if (want !== got)
        flag($sformatf("lane %0d %s: expected %0h, got %0h", lane, name, want, got));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_lanes.size() == 0) begin
        flag($sformatf("result for lane %0d with nothing outstanding", got.lane_number));
        return;
      end
      want = due_lanes.pop_front();
      compare("lane_number", want.lane_number, want.lane_number, got.lane_number);
      compare("lane_error_count", want.lane_number, want.lane_error_count,
              got.lane_error_count);
      compare("bad_byte_total", want.lane_number, want.bad_byte_total, got.bad_byte_total);
      compare("bad_bit_total", want.lane_number, want.bad_bit_total, got.bad_bit_total);
      compare("span_start", want.lane_number, want.span_start, got.span_start);
      compare("span_width", want.lane_number, want.span_width, got.span_width);
      compare("fault_mask", want.lane_number, want.fault_mask, got.fault_mask);
      compare("mismatch_seen", want.lane_number, want.mismatch_seen, got.mismatch_seen);
      compare("final_result", want.lane_number, want.final_result, got.final_result);
    endfunction

    function int pending();
      return due_lanes.size();
    endfunction
  endclass

  logic    clk  = 1'b0;
  logic    rst  = 1'b1;
  logic    push = 1'b0;
  logic    pop  = 1'b0;
  pair_t   pair = '0;
  logic    full;
  logic    empty;
  result_t result;

  syndrome_board sb;
  bit send_idle = 1'b1;
  bit take_idle = 1'b1;
  int hold_len  = 0;

  byte_compare_error_syndrome_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .pair   (pair),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always #10 clk = ~clk;

  initial begin
    #(20 * 1000000);
    $display("FAILURE");
    $finish;
  end

  // both sides sampled with pre-edge values
  always @(posedge clk) begin
    if (!rst && push && !full) sb.accumulate_pair(pair);
    if (!rst && pop && !empty) sb.check_result(result);
  end

  function automatic pair_t pair_of(logic [7:0] e, logic [7:0] o, logic f);
    pair_t p;
    p.expected_byte = e;
    p.observed_byte = o;
    p.final_pair    = f;
    return p;
  endfunction

  task automatic send_pair(input pair_t p);
    int gap;
    gap = send_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    pair <= p;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_run(input int len, input int bad_pct);
    pair_t p;
    int    k;
    for (k = 0; k < len; k++) begin
      p.expected_byte = 8'($urandom);
      p.observed_byte = p.expected_byte;
      if ($urandom_range(1, 100) <= bad_pct) begin
        if ($urandom_range(0, 1) != 0)
          p.observed_byte = p.observed_byte ^ 8'(1 << $urandom_range(0, 7));
        else
          p.observed_byte = p.observed_byte ^ 8'($urandom_range(1, 255));
      end
      p.final_pair = (k == len - 1);
      send_pair(p);
    end
  endtask

  // sender stops until every outstanding lane report is back
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : take_results
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        pop <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        gap = take_idle ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        pop <= 1'b1;
        @(posedge clk);
        while (empty && hold_len == 0) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int         n;
    int         len;
    int         sent;
    int         rate;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // clean single-pair run: all zero syndrome
    send_pair(pair_of(8'h5A, 8'h5A, 1'b1));
    // walk a single wrong bit through every lane, then the byte extremes
    send_pair(pair_of(8'h00, 8'h00, 1'b0));
    for (n = 0; n < LANES; n++) send_pair(pair_of(8'h00, 8'(1 << n), 1'b0));
    send_pair(pair_of(8'hFF, 8'h00, 1'b0));
    send_pair(pair_of(8'h00, 8'hFF, 1'b0));
    send_pair(pair_of(8'hFF, 8'hFF, 1'b1));
    // miscompare only at position zero, clean tail
    send_pair(pair_of(8'h3C, 8'hC3, 1'b0));
    send_pair(pair_of(8'h55, 8'h55, 1'b0));
    send_pair(pair_of(8'hAA, 8'hAA, 1'b1));
    // the final pair itself is the only miscompare
    send_pair(pair_of(8'h80, 8'h7F, 1'b1));
    drain();

    // receiver holds off while short runs pile up and the input stalls
    hold_len = 300;
    for (n = 0; n < 6; n++) send_run(2, 60);
    drain();

    sent = 0;
    while (sent < 165) begin
      send_idle = ($urandom_range(0, 3) != 0);
      take_idle = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0:       rate = 0;
        1:       rate = 15;
        2:       rate = 60;
        default: rate = 100;
      endcase
      send_run(len, rate);
      sent += len;
      if ($urandom_range(0, 7) == 0) drain();
    end
    drain();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
